// ===== src/arpt_pkg.sv =====
`default_nettype none

package arpt_pkg;

	localparam int ENTRIES_DEF = 32;
	localparam int OP_W = 2;
	localparam int IP_W = 32;
	localparam int MAC_W = 48;
	localparam int SLOT_W = 5;
	localparam int AGE_W = 8;
	localparam int TIME_W = 32;
	localparam logic [AGE_W-1:0] MAX_AGE_RESET = AGE_W'(15);

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_TICK   = 2'd2
	} op_t;

	typedef struct packed {
		logic [IP_W-1:0]   ip;
		logic [MAC_W-1:0]  mac;
		logic [TIME_W-1:0] stamp;
	} entry_t;

endpackage

`default_nettype wire

// ===== src/arpt_mem.sv =====
`default_nettype none

module arpt_mem #(
	parameter int ENTRIES = arpt_pkg::ENTRIES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(ENTRIES)-1:0] waddr,
	input  wire arpt_pkg::entry_t           wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(ENTRIES)-1:0] raddr,
	output      arpt_pkg::entry_t           rdata
);
	import arpt_pkg::*;

	entry_t mem_q [ENTRIES];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/arp_table_with_aging_top.sv =====
// channel   direction  handshake              word
// --------  ---------  ---------------------  ------------------------------
// command   in         start & !busy          operation, ip_addr, mac_addr
// result    out        done (one cycle)       found, mac_out, slot
// config    in         cfg_we                 cfg_data (max_age)
//
// Lookup and tick sweep the entry memory one slot per cycle through its single
// read port; a lookup ends early at the first slot that hits. Insert scans the
// valid flags, one per cycle, up to the first free slot or the last slot.
// busy drops in the done cycle, so the next command may be taken there.
// arst_n clears valid flags, seconds counter and control; max_age returns to 15.
// The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none

module arp_table_with_aging_top #(
	parameter int ENTRIES = arpt_pkg::ENTRIES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output      logic                          busy,
	input  wire logic [arpt_pkg::OP_W-1:0]     operation,
	input  wire logic [arpt_pkg::IP_W-1:0]     ip_addr,
	input  wire logic [arpt_pkg::MAC_W-1:0]    mac_addr,
	output      logic                          done,
	output      logic                          found,
	output      logic [arpt_pkg::MAC_W-1:0]    mac_out,
	output      logic [arpt_pkg::SLOT_W-1:0]   slot,
	input  wire logic                          cfg_we,
	input  wire logic [arpt_pkg::AGE_W-1:0]    cfg_data
);
	import arpt_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [IP_W-1:0]     ip_q;
	logic [MAC_W-1:0]    in_mac_q;
	logic [TIME_W-1:0]   now_q;
	logic [AGE_W-1:0]    max_age_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [IW-1:0]       cnt_q;
	logic                issue_q;
	logic                rd_pend_s1;
	logic [IW-1:0]       idx_s1;
	logic                done_q;
	logic                found_q;
	logic [MAC_W-1:0]    mac_out_q;
	logic [SLOT_W-1:0]   slot_q;

	logic                accept;
	logic                rd_en;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	entry_t              wr_data;
	entry_t              rd_data;
	logic                finish;
	logic                fin_found;
	logic [MAC_W-1:0]    fin_mac;
	logic [SLOT_W-1:0]   fin_slot;
	logic                clr_en;
	logic [TIME_W-1:0]   age;
	logic                s1_valid;

	assign accept = start && (state_q == ST_IDLE);
	assign rd_en = (state_q == ST_SCAN) && issue_q
		&& (op_q == OP_LOOKUP || op_q == OP_TICK);
	assign s1_valid = rd_pend_s1 && valid_q[idx_s1];
	assign age = now_q - rd_data.stamp;
	assign wr_data = '{ip: ip_q, mac: in_mac_q, stamp: now_q};

	arpt_mem #(
		.ENTRIES(ENTRIES)
	) u_mem (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(cnt_q),
		.rdata(rd_data)
	);

	always_comb begin
		finish = 1'b0;
		fin_found = 1'b0;
		fin_mac = '0;
		fin_slot = '0;
		wr_en = 1'b0;
		wr_addr = cnt_q;
		clr_en = 1'b0;
		if (state_q == ST_SCAN) begin
			case (op_q)
				OP_LOOKUP: begin
					if (s1_valid && rd_data.ip == ip_q) begin
						finish = 1'b1;
						fin_found = 1'b1;
						fin_mac = rd_data.mac;
						fin_slot = SLOT_W'(idx_s1);
					end else if (rd_pend_s1 && idx_s1 == LAST) begin
						finish = 1'b1;
					end
				end
				OP_INSERT: begin
					if (!valid_q[cnt_q] || cnt_q == LAST) begin
						finish = 1'b1;
						wr_en = 1'b1;
						wr_addr = valid_q[cnt_q] ? '0 : cnt_q;
						fin_slot = SLOT_W'(wr_addr);
					end
				end
				OP_TICK: begin
					clr_en = s1_valid && (age > TIME_W'(max_age_q));
					finish = rd_pend_s1 && idx_s1 == LAST;
				end
				default: begin
					finish = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q <= '0;
			max_age_q <= MAX_AGE_RESET;
			valid_q <= '0;
			issue_q <= 1'b0;
			rd_pend_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
			rd_pend_s1 <= rd_en;
			if (cfg_we) begin
				max_age_q <= cfg_data;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (clr_en) begin
				valid_q[idx_s1] <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						issue_q <= 1'b1;
						if (operation == OP_TICK) begin
							now_q <= now_q + TIME_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
					if (issue_q && cnt_q == LAST) begin
						issue_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload, scan pointer and result registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept) begin
			op_q <= operation;
			ip_q <= ip_addr;
			in_mac_q <= mac_addr;
			cnt_q <= '0;
		end else if (state_q == ST_SCAN && issue_q && cnt_q != LAST) begin
			cnt_q <= cnt_q + IW'(1);
		end
		if (finish) begin
			found_q <= fin_found;
			mac_out_q <= fin_mac;
			slot_q <= fin_slot;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign found = found_q;
	assign mac_out = mac_out_q;
	assign slot = slot_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a command in progress");

	a_hit_only_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (op_q == OP_LOOKUP))
		else $error("hit reported for a non-lookup command");

	a_tick_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_TICK) |=> (now_q == $past(now_q) + TIME_W'(1)))
		else $error("seconds counter did not advance on tick");

	a_insert_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(wr_addr)])
		else $error("inserted slot not marked valid");

endmodule

`default_nettype wire

// ===== tb/sv/arp_table_with_aging_top_tb.sv =====
`default_nettype none

module arp_table_with_aging_top_tb;
	import arpt_pkg::*;

	localparam int N_SLOTS = ENTRIES_DEF;
	localparam int IP_POOL = 12;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic              found;
		logic [MAC_W-1:0]  mac;
		logic [SLOT_W-1:0] slot;
	} reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [OP_W-1:0]    operation = '0;
	logic [IP_W-1:0]    ip_addr = '0;
	logic [MAC_W-1:0]   mac_addr = '0;
	logic               cfg_we = 1'b0;
	logic [AGE_W-1:0]   cfg_data = '0;
	logic               busy;
	logic               done;
	logic               found;
	logic [MAC_W-1:0]   mac_out;
	logic [SLOT_W-1:0]  slot;

	logic               tbl_valid [N_SLOTS];
	logic [IP_W-1:0]    tbl_ip [N_SLOTS];
	logic [MAC_W-1:0]   tbl_mac [N_SLOTS];
	logic [TIME_W-1:0]  tbl_stamp [N_SLOTS];
	logic [TIME_W-1:0]  seconds = '0;
	logic [AGE_W-1:0]   age_limit = MAX_AGE_RESET;
	logic [IP_W-1:0]    ip_pool [IP_POOL];
	reply_t             pending_replies [$];
	reply_t             want;
	int                 bad_replies = 0;
	int                 idle_pct = 0;

	always #5 clk = ~clk;

	arp_table_with_aging_top #(
		.ENTRIES(N_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.ip_addr(ip_addr),
		.mac_addr(mac_addr),
		.done(done),
		.found(found),
		.mac_out(mac_out),
		.slot(slot),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	task automatic note_bad(input string msg);
		if (bad_replies < 10) begin
			$display("%s", msg);
		end
		bad_replies++;
	endtask

	task automatic apply_command(input logic [OP_W-1:0] op, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac);
		reply_t r;
		int target;
		logic [TIME_W-1:0] age;
		r = '0;
		target = 0;
		case (op)
			OP_LOOKUP: begin
				for (int k = N_SLOTS - 1; k >= 0; k--) begin
					if (tbl_valid[k] && tbl_ip[k] == ip) begin
						r.found = 1'b1;
						r.mac = tbl_mac[k];
						r.slot = SLOT_W'(k);
					end
				end
			end
			OP_INSERT: begin
				for (int k = N_SLOTS - 1; k >= 0; k--) begin
					if (!tbl_valid[k]) begin
						target = k;
					end
				end
				tbl_valid[target] = 1'b1;
				tbl_ip[target] = ip;
				tbl_mac[target] = mac;
				tbl_stamp[target] = seconds;
				r.slot = SLOT_W'(target);
			end
			OP_TICK: begin
				seconds = seconds + TIME_W'(1);
				for (int k = 0; k < N_SLOTS; k++) begin
					age = seconds - tbl_stamp[k];
					if (tbl_valid[k] && age > TIME_W'(age_limit)) begin
						tbl_valid[k] = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		pending_replies.push_back(r);
	endtask

	task automatic send_word(input logic [OP_W-1:0] op, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac);
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(40, 0)) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		operation = op;
		ip_addr = ip;
		mac_addr = mac;
		do @(posedge clk); while (busy !== 1'b0);
		apply_command(op, ip, mac);
	endtask

	task automatic drain;
		@(negedge clk);
		start = 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
	endtask

	task automatic write_max_age(input logic [AGE_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		age_limit = v;
	endtask

	task automatic send_random;
		int w;
		logic [OP_W-1:0] op;
		logic [IP_W-1:0] ip;
		logic [MAC_W-1:0] mac;
		w = $urandom_range(99);
		if (w < 45) begin
			op = OP_LOOKUP;
		end else if (w < 80) begin
			op = OP_INSERT;
		end else if (w < 95) begin
			op = OP_TICK;
		end else begin
			op = OP_UNUSED;
		end
		if ($urandom_range(3) != 0) begin
			ip = ip_pool[$urandom_range(IP_POOL - 1)];
		end else begin
			ip = $urandom;
		end
		mac = MAC_W'({$urandom, $urandom});
		send_word(op, ip, mac);
	endtask

	task automatic test_lookup_insert;
		idle_pct = 0;
		send_word(OP_LOOKUP, '0, '0);
		send_word(OP_INSERT, '0, '0);
		send_word(OP_INSERT, '1, '1);
		send_word(OP_LOOKUP, '1, '0);
		send_word(OP_INSERT, '1, 48'h1234_5678_9abc);
		send_word(OP_LOOKUP, '1, '1);
		send_word(OP_LOOKUP, '0, '1);
		send_word(OP_UNUSED, '0, '1);
		send_word(OP_TICK, '1, '1);
		send_word(OP_LOOKUP, '0, '0);
	endtask

	task automatic test_aging;
		write_max_age(8'd2);
		send_word(OP_INSERT, ip_pool[2], 48'ha5a5_5a5a_0ff0);
		send_word(OP_TICK, '0, '0);
		send_word(OP_TICK, '0, '0);
		send_word(OP_LOOKUP, ip_pool[2], '0);
		send_word(OP_TICK, '0, '0);
		send_word(OP_LOOKUP, ip_pool[2], '0);
		write_max_age(8'd0);
		send_word(OP_INSERT, ip_pool[3], 48'hfeed_0000_beef);
		send_word(OP_LOOKUP, ip_pool[3], '0);
		send_word(OP_TICK, '0, '0);
		send_word(OP_LOOKUP, ip_pool[3], '0);
	endtask

	task automatic test_random(input logic [AGE_W-1:0] age, input int pct, input int n);
		write_max_age(age);
		idle_pct = pct;
		repeat (n) send_random();
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_replies.size() == 0) begin
				note_bad($sformatf("unexpected reply: found %0d mac %h slot %0d",
					found, mac_out, slot));
			end else begin
				want = pending_replies.pop_front();
				if (found !== want.found || mac_out !== want.mac || slot !== want.slot) begin
					note_bad($sformatf(
						"reply mismatch: found %0d/%0d mac %h/%h slot %0d/%0d",
						want.found, found, want.mac, mac_out, want.slot, slot));
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		for (int k = 0; k < N_SLOTS; k++) begin
			tbl_valid[k] = 1'b0;
			tbl_ip[k] = '0;
			tbl_mac[k] = '0;
			tbl_stamp[k] = '0;
		end
		ip_pool[0] = '0;
		ip_pool[1] = '1;
		for (int k = 2; k < IP_POOL; k++) begin
			ip_pool[k] = $urandom;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_lookup_insert();
		test_aging();
		test_random(8'd255, 0, 200);
		test_random(8'd0, 72, 200);
		test_random(AGE_W'($urandom_range(40, 1)), 18, 200);
		test_random(8'd8, 0, 200);

		drain();
		repeat (40) @(posedge clk);
		if (bad_replies == 0 && pending_replies.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/arpt_pkg.sv
src/arpt_mem.sv
src/arp_table_with_aging_top.sv
tb/sv/arp_table_with_aging_top_tb.sv
